### hw/rtl/rrfc_pkg.sv
// ----------------------------------------------------------------------------
// rrfc_pkg
// Shared types, constants and the CRC byte step for the reader reply frame
// checker.
// ----------------------------------------------------------------------------
package rrfc_pkg;

   // Frame layout.
   localparam int unsigned ID_BYTES_DEFAULT = 12;
   localparam int unsigned ID_START         = 7;
   localparam int unsigned ID_SHOWN         = 12;
   localparam int unsigned MAX_FRAME        = 127;

   // CRC-16/CCITT-FALSE.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   // Configuration registers.
   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_ADDR_W-1:0] REG_EXPECTED_TYPE    = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_EXPECTED_COMMAND = 1'd1;
   localparam logic [7:0] EXPECTED_TYPE_RESET    = 8'h02;
   localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'h22;

   // Result status codes.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_HEADER    = 3'd1;
   localparam logic [2:0] STATUS_CRC       = 3'd2;
   localparam logic [2:0] STATUS_TOO_SHORT = 3'd3;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

   // Stream widths.
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_BITS   = 3 + 48 + 48;
   localparam int unsigned RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // One result item.
   typedef struct packed {
      logic [47:0] id_low;
      logic [47:0] id_high;
      logic [2:0]  status;
   } rrfc_result_type;

   // One byte of CRC, MSB first.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### hw/rtl/reader_reply_frame_checker.sv
// ----------------------------------------------------------------------------
// reader_reply_frame_checker
// Checks reply frames from an RFID reader and extracts the tag ID.
//
// The req_ stream carries one frame byte per transfer, tlast on the last
// byte. Byte 1 must match expected_type, byte 2 expected_command, and a
// CRC-16/CCITT-FALSE over byte 1 up to the third-last byte must match the
// last two bytes, high byte first. Frame bytes 7 onward form the tag ID.
// Each frame end gives one rsp_ transfer with a status and the ID (zero
// unless the status is ok). The csr_ port sets the two expected values.
// Throughput is one byte per cycle while req_tready is high: the whole
// byte step, CRC included, is one level of logic between the frame state
// registers. A result register plus one skid entry buffer results: each
// result is registered in the result register, or in the skid entry while
// an earlier result waits. req_tready falls only when two results are
// waiting; it rises the cycle after the receiver takes one.
// Reset clears the frame state, the result buffer and returns the
// configuration to its defaults; the ID store keeps no reset value.
// ----------------------------------------------------------------------------
module reader_reply_frame_checker #(
   parameter int unsigned ID_BYTES = rrfc_pkg::ID_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [rrfc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rrfc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // Frame bytes in.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rrfc_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] rx_byte
   input  logic                                req_tlast,  // frame_end
   // Results out.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] status, [50:3] id_high, [98:51] id_low, [103:99] zero
   output logic [rrfc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import rrfc_pkg::*;

   logic            item_accept;
   logic            result_push;
   logic            buf_full;
   rrfc_result_type result;
   rrfc_result_type rsp_result;

   assign req_tready  = !buf_full;
   assign item_accept = req_tvalid && req_tready;

   // Per-byte frame processing.
   rrfc_frame_core #(
      .ID_BYTES (ID_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .item_accept (item_accept),
      .rx_byte     (req_tdata),
      .frame_end   (req_tlast),
      .result_push (result_push),
      .result      (result)
   );

   // Result buffering toward the receiver.
   rrfc_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (buf_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_BITS)'(0), rsp_result.id_low,
                       rsp_result.id_high, rsp_result.status};

endmodule

### hw/rtl/rrfc_frame_core.sv
// ----------------------------------------------------------------------------
// rrfc_frame_core
// Per-byte frame state: header check, running CRC, byte count and tag ID
// capture, plus the result computed on the last byte of a frame.
// ----------------------------------------------------------------------------
module rrfc_frame_core #(
   parameter int unsigned ID_BYTES = rrfc_pkg::ID_BYTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rrfc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [rrfc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 item_accept,
   input  logic [7:0]                           rx_byte,
   input  logic                                 frame_end,
   output logic                                 result_push,
   output rrfc_pkg::rrfc_result_type            result
);
   import rrfc_pkg::*;

   localparam logic [7:0] IDX_TYPE      = 8'd1;
   localparam logic [7:0] IDX_COMMAND   = 8'd2;
   localparam logic [7:0] IDX_CRC_FIRST = 8'd3;
   localparam logic [7:0] IDX_SAT       = 8'hFF;
   localparam logic [7:0] IDX_TOO_LONG  = 8'(MAX_FRAME);
   localparam logic [7:0] IDX_SHORT     = 8'(ID_START + ID_BYTES - 1);

   logic [7:0]  exp_type_ff;
   logic [7:0]  exp_cmd_ff;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  held0_ff, held1_ff;
   logic        header_ok_ff, header_ok_in;
   logic [7:0]  id_store_ff [ID_BYTES];
   logic [7:0]  id_view [ID_BYTES];
   logic [7:0]  id_shown [ID_SHOWN];
   logic [2:0]  status;
   logic [47:0] id_high, id_low;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_type_ff <= EXPECTED_TYPE_RESET;
         exp_cmd_ff  <= EXPECTED_COMMAND_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_EXPECTED_TYPE:    exp_type_ff <= csr_wdata;
            REG_EXPECTED_COMMAND: exp_cmd_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next frame state and the status that a frame end would report.
   always_comb begin
      header_ok_in = header_ok_ff;
      if (index_ff == IDX_TYPE && rx_byte != exp_type_ff) begin
         header_ok_in = 1'b0;
      end
      if (index_ff == IDX_COMMAND && rx_byte != exp_cmd_ff) begin
         header_ok_in = 1'b0;
      end
      // The CRC trails the input by two bytes so the trailer is never included.
      crc_in   = (index_ff >= IDX_CRC_FIRST) ? crc_step(crc_ff, held0_ff) : crc_ff;
      index_in = (index_ff != IDX_SAT) ? index_ff + 8'd1 : index_ff;

      if (index_ff >= IDX_TOO_LONG) begin
         status = STATUS_TOO_LONG;
      end else if (index_ff < IDX_SHORT) begin
         status = STATUS_TOO_SHORT;
      end else if (!header_ok_in) begin
         status = STATUS_HEADER;
      end else if (crc_in != {held1_ff, rx_byte}) begin
         status = STATUS_CRC;
      end else begin
         status = STATUS_OK;
      end
   end

   // Frame state registers; a frame end returns them to their start values.
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         index_ff     <= 8'd0;
         held0_ff     <= 8'd0;
         held1_ff     <= 8'd0;
         header_ok_ff <= 1'b1;
      end else if (item_accept) begin
         if (frame_end) begin
            crc_ff       <= CRC_INIT;
            index_ff     <= 8'd0;
            held0_ff     <= 8'd0;
            held1_ff     <= 8'd0;
            header_ok_ff <= 1'b1;
         end else begin
            crc_ff       <= crc_in;
            index_ff     <= index_in;
            held0_ff     <= held1_ff;
            held1_ff     <= rx_byte;
            header_ok_ff <= header_ok_in;
         end
      end
   end

   // Tag ID capture; each slot has its own fixed byte position in the frame.
   for (genvar k = 0; k < ID_BYTES; k++) begin : g_id
      logic hit;
      assign hit        = (index_ff == 8'(ID_START + k));
      assign id_view[k] = hit ? rx_byte : id_store_ff[k];
      always_ff @(posedge clock) begin
         if (item_accept && hit) begin
            id_store_ff[k] <= rx_byte;
         end
      end
   end

   // Slots beyond the configured ID length show as zero.
   for (genvar k = 0; k < ID_SHOWN; k++) begin : g_shown
      if (k < ID_BYTES) begin : g_have
         assign id_shown[k] = id_view[k];
      end else begin : g_none
         assign id_shown[k] = 8'h00;
      end
   end

   // Pack the ID, first byte most significant.
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         id_high[47 - 8*k -: 8] = id_shown[k];
         id_low[47 - 8*k -: 8]  = id_shown[k + 6];
      end
   end

   assign result_push    = item_accept && frame_end;
   assign result.status  = status;
   assign result.id_high = (status == STATUS_OK) ? id_high : 48'h0;
   assign result.id_low  = (status == STATUS_OK) ? id_low  : 48'h0;

endmodule

### hw/rtl/rrfc_out_skid.sv
// ----------------------------------------------------------------------------
// rrfc_out_skid
// Result register with one skid entry, so the input side keeps moving while
// a result waits for the receiver.
// ----------------------------------------------------------------------------
module rrfc_out_skid (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rrfc_pkg::rrfc_result_type push_data,
   output logic                      full,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rrfc_pkg::rrfc_result_type out_data
);
   import rrfc_pkg::*;

   logic            main_valid_ff;
   logic            skid_valid_ff;
   rrfc_result_type main_ff;
   rrfc_result_type skid_ff;
   logic            pop;

   assign pop       = main_valid_ff && out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Control: the skid entry fills only while the result register is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

endmodule

### hw/rtl/rrfc_checker.sv
// ----------------------------------------------------------------------------
// rrfc_checker
// Port-level assertions for the reader reply frame checker, bound to the top.
// ----------------------------------------------------------------------------
module rrfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rrfc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rrfc_pkg::*;

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Status is one of the defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] == STATUS_OK || rsp_tdata[2:0] == STATUS_HEADER ||
                      rsp_tdata[2:0] == STATUS_CRC || rsp_tdata[2:0] == STATUS_TOO_SHORT ||
                      rsp_tdata[2:0] == STATUS_TOO_LONG))
      else $error("undefined status code");

   // A failed frame reports no ID.
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != STATUS_OK |-> rsp_tdata[RSP_BITS-1:3] == '0)
      else $error("ID shown on a failed frame");

   // Reset empties the result buffer.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result buffer not empty after reset");

   // The input side is never blocked while no result waits.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result buffer");

endmodule

bind reader_reply_frame_checker rrfc_checker u_rrfc_checker (.*);
